@@ hdl/gsa_pkg.sv @@
// types and constants shared by the slot allocator modules
package gsa_pkg;

	localparam int CAPACITY = 1024;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = IDX_W + 1;
	localparam int GEN_W    = 16;

	localparam logic OP_CREATE  = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_IGNORED = 2'd2;

	typedef struct packed {
		logic             operation;
		logic [IDX_W-1:0] slot_index;
		logic [GEN_W-1:0] slot_generation;
	} req_t;

	typedef struct packed {
		logic [IDX_W-1:0] handle_index;
		logic [GEN_W-1:0] handle_generation;
		logic [1:0]       status;
	} rsp_t;

	typedef struct packed {
		logic launch;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic rsp_full;
	} sts_t;

endpackage

@@ hdl/gsa_ctrl.sv @@
// request sequencer: read launch, then commit once the result register is free
module gsa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  logic          rsp_stall,
	input  gsa_pkg::sts_t sts,
	output gsa_pkg::cmd_t cmd
);
	import gsa_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd.launch = 1'b0;
		cmd.commit = 1'b0;
		state_d    = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.launch = 1'b1;
					state_d    = S_EXEC;
				end
			end
			S_EXEC: begin
				if (!sts.rsp_full || !rsp_stall) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign req_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_no_launch_and_commit: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.launch && cmd.commit))
		else $error("launch and commit in the same cycle");

	a_commit_follows_launch: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.launch |=> (state_q == S_EXEC))
		else $error("launched beat not held for commit");

	a_stall_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.launch |=> req_stall)
		else $error("request taken while a beat is in flight");

endmodule

@@ hdl/gsa_dp.sv @@
// slot tables, free-list pointers, counters and result register
module gsa_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  gsa_pkg::cmd_t cmd,
	output gsa_pkg::sts_t sts,
	input  gsa_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output gsa_pkg::rsp_t rsp
);
	import gsa_pkg::*;

	logic [IDX_W-1:0] link_mem [CAPACITY];
	logic [GEN_W-1:0] gen_mem  [CAPACITY];

	req_t             req_q;
	logic [IDX_W-1:0] link_rd_q;
	logic [GEN_W-1:0] gen_rd_q;
	logic [IDX_W-1:0] head_q, head_d;
	logic [IDX_W-1:0] tail_q, tail_d;
	logic [CNT_W-1:0] free_count_q, free_count_d;
	logic [CNT_W-1:0] issued_q, issued_d;
	logic             rsp_valid_q;
	rsp_t             rsp_q, rsp_d;

	logic [IDX_W-1:0] rd_addr;
	logic             link_we;
	logic [IDX_W-1:0] link_wa;
	logic [IDX_W-1:0] link_wd;
	logic             gen_we;
	logic [IDX_W-1:0] gen_wa;
	logic [GEN_W-1:0] gen_wd;
	logic             rel_bad;
	logic             rel_bad_in;
	logic             link_clr;

	assign rd_addr = (req.operation == OP_CREATE) ? head_q : req.slot_index;

	// a released slot becomes the new tail, so its link is cleared as the beat is taken
	assign rel_bad_in = (req.slot_generation == '0)
		|| ({1'b0, req.slot_index} >= issued_q)
		|| (free_count_q == CNT_W'(CAPACITY));
	assign link_clr = cmd.launch && (req.operation == OP_RELEASE) && !rel_bad_in;

	// table ports
	always_ff @(posedge clk) begin
		if (cmd.launch) begin
			req_q     <= req;
			link_rd_q <= link_mem[rd_addr];
			gen_rd_q  <= gen_mem[rd_addr];
		end
		if (link_clr) begin
			link_mem[req.slot_index] <= '0;
		end else if (link_we) begin
			link_mem[link_wa] <= link_wd;
		end
		if (gen_we) begin
			gen_mem[gen_wa] <= gen_wd;
		end
	end

	assign rel_bad = (req_q.slot_generation == '0)
		|| ({1'b0, req_q.slot_index} >= issued_q)
		|| (free_count_q == CNT_W'(CAPACITY));

	always_comb begin
		head_d       = head_q;
		tail_d       = tail_q;
		free_count_d = free_count_q;
		issued_d     = issued_q;
		link_we      = 1'b0;
		link_wa      = req_q.slot_index;
		link_wd      = '0;
		gen_we       = 1'b0;
		gen_wa       = req_q.slot_index;
		gen_wd       = gen_rd_q + GEN_W'(1);
		rsp_d        = '0;
		rsp_d.status = ST_DONE;
		if (cmd.commit) begin
			if (req_q.operation == OP_CREATE) begin
				if (free_count_q != '0) begin
					// pop the oldest released slot
					rsp_d.handle_index      = head_q;
					rsp_d.handle_generation = gen_rd_q;
					free_count_d            = free_count_q - CNT_W'(1);
					if (free_count_q == CNT_W'(1)) begin
						head_d = '0;
						tail_d = '0;
					end else begin
						head_d = link_rd_q;
					end
				end else if (issued_q == CNT_W'(CAPACITY)) begin
					rsp_d.status = ST_FULL;
				end else begin
					// fresh slot
					rsp_d.handle_index      = issued_q[IDX_W-1:0];
					rsp_d.handle_generation = GEN_W'(1);
					gen_we                  = 1'b1;
					gen_wa                  = issued_q[IDX_W-1:0];
					gen_wd                  = GEN_W'(1);
					issued_d                = issued_q + CNT_W'(1);
				end
			end else if (rel_bad) begin
				rsp_d.status = ST_IGNORED;
			end else begin
				// push onto the tail, bump the generation
				gen_we       = 1'b1;
				link_we      = 1'b1;
				free_count_d = free_count_q + CNT_W'(1);
				tail_d       = req_q.slot_index;
				if (free_count_q == '0) begin
					head_d  = req_q.slot_index;
					link_wa = req_q.slot_index;
					link_wd = '0;
				end else begin
					link_wa = tail_q;
					link_wd = (tail_q == req_q.slot_index) ? '0 : req_q.slot_index;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q       <= '0;
			tail_q       <= '0;
			free_count_q <= '0;
			issued_q     <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			head_q       <= head_d;
			tail_q       <= tail_d;
			free_count_q <= free_count_d;
			issued_q     <= issued_d;
			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign rsp          = rsp_q;
	assign sts.rsp_full = rsp_valid_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(free_count_q <= CNT_W'(CAPACITY)) && (issued_q <= CNT_W'(CAPACITY)))
		else $error("counter beyond capacity");

	a_empty_pointers: assert property (@(posedge clk) disable iff (!arst_n)
		(free_count_q == '0) |-> ((head_q == '0) && (tail_q == '0)))
		else $error("empty free list with stale pointers");

	a_commit_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!rsp_valid_q || !rsp_stall))
		else $error("result register overwritten while stalled");

	a_single_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> ((free_count_q == $past(free_count_q))
			|| (free_count_q == $past(free_count_q) + CNT_W'(1))
			|| (free_count_q == $past(free_count_q) - CNT_W'(1))))
		else $error("free count moved by more than one");

endmodule

@@ hdl/generational_slot_allocator.sv @@
// generational slot allocator top level
//
// hands out slot handles (index plus generation) and takes them back.
// request channel req/req_valid/req_stall: operation create or release,
// with the handle to release. result channel rsp/rsp_valid/rsp_stall:
// one result beat per request, carrying the handle on create and a status.
// a create reuses the oldest released slot first, then a fresh slot with
// generation 1, and reports full when none is left. a release with a
// null generation, an index never issued, or a full free list is ignored.
// each request first does the synchronous read of the link and generation
// tables, then the update and write-back. the result is registered and
// appears the cycle after the update. while a result waits under rsp_stall
// the next request is still taken and read, and it commits once the result
// register has been emptied.
// reset clears the free-list pointers and counters; the tables need no
// clearing, since an entry's value is only used after it has been written.
module generational_slot_allocator (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  gsa_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output gsa_pkg::rsp_t rsp
);
	import gsa_pkg::*;

	cmd_t cmd;
	sts_t sts;

	gsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	gsa_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
